### hw/rtl/mono_framebuffer_2x_scaler_macros.svh
// Assertion macros for the monochrome 2x frame buffer scaler.
// Uses clk_i and rst_ni of the module that includes this header.
`ifndef MONO_FRAMEBUFFER_2X_SCALER_MACROS_SVH
`define MONO_FRAMEBUFFER_2X_SCALER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define MFBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define MFBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mfbs_pkg.sv
// Shared types, codes and helpers of the 2x frame buffer scaler.
// No dependencies; imported by every module of the block.
package mfbs_pkg;

  // Operation codes of an input beat
  localparam logic [1:0] OpClear    = 2'd0;
  localparam logic [1:0] OpSetPixel = 2'd1;
  localparam logic [1:0] OpEmit     = 2'd2;

  // Colour value that clears a pixel bit
  localparam logic [7:0] ColourBlack = 8'd1;

  // Store contents after reset
  localparam logic [7:0] ResetFill = 8'hFF;

  // Address width that covers the largest store (256 rows of 32 bytes)
  localparam int unsigned AddrMaxW = 13;

  // Command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_SET,
    CMD_EMIT
  } cmd_kind_e;

  // Classified command handed from front to back
  typedef struct packed {
    cmd_kind_e           kind;
    logic [AddrMaxW-1:0] addr;
    logic [7:0]          mask;
    logic [7:0]          data;
  } cmd_t;

  // Flow control seen by the front
  typedef struct packed {
    logic queue_full;
    logic init_busy;
  } front_ctl_t;

  // Double every bit of a byte, MSB first
  function automatic logic [15:0] widen_byte(input logic [7:0] v);
    logic [15:0] w;
    for (int i = 0; i < 8; i++) begin
      w[2*i +: 2] = {2{v[i]}};
    end
    return w;
  endfunction

endpackage

### hw/rtl/mfbs_front.sv
// Front end: accepts input beats, maps pixel coordinates to a store address.
// Depends on mfbs_pkg; feeds mfbs_fifo.
module mfbs_front import mfbs_pkg::*; #(
  parameter int unsigned DISPLAY_COLS = 200,
  parameter int unsigned DISPLAY_ROWS = 150
) (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] pixel_col_i,
  input  logic [7:0] pixel_row_i,
  input  logic [7:0] value_i,
  input  logic       orient_keep_i,
  input  front_ctl_t ctl_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int unsigned Stride = (DISPLAY_COLS + 7) / 8;

  logic       col_ok;
  logic       row_ok;
  logic       keep;
  logic [7:0] col_m;
  logic [7:0] row_m;

  // Range check and mirror
  always_comb begin
    col_ok = {1'b0, pixel_col_i} < 9'(DISPLAY_COLS);
    row_ok = {1'b0, pixel_row_i} < 9'(DISPLAY_ROWS);
    if (orient_keep_i) begin
      // column is only reversed
      col_m = 8'(DISPLAY_COLS - 1) - pixel_col_i;
      row_m = pixel_row_i;
    end else begin
      // mirror and reverse cancel on the column
      col_m = pixel_col_i;
      row_m = 8'(DISPLAY_ROWS - 1) - pixel_row_i;
    end
  end

  // Classify the beat
  always_comb begin
    cmd_o.addr = AddrMaxW'(row_m) * AddrMaxW'(Stride) + AddrMaxW'(col_m[7:3]);
    cmd_o.mask = 8'h80 >> col_m[2:0];
    cmd_o.data = value_i;
    case (operation_i)
      OpClear: begin
        cmd_o.kind = CMD_CLEAR;
        keep       = 1'b1;
      end
      OpSetPixel: begin
        cmd_o.kind = CMD_SET;
        keep       = col_ok && row_ok;
      end
      OpEmit: begin
        cmd_o.kind = CMD_EMIT;
        keep       = 1'b1;
      end
      default: begin
        cmd_o.kind = CMD_CLEAR;
        keep       = 1'b0;
      end
    endcase
  end

  // Hold input while the queue is full or the store is being initialized
  assign in_stall_o = ctl_i.queue_full || ctl_i.init_busy;
  assign push_o     = in_valid_i && !in_stall_o && keep;

endmodule

### hw/rtl/mfbs_fifo.sv
// Two-entry command queue between the front and back ends.
// Depends on mfbs_pkg.
module mfbs_fifo import mfbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   count_q, count_d;

  assign full_o  = count_q == (QueuePtrW + 1)'(QueueDepth);
  assign empty_o = count_q == '0;
  assign cmd_o   = slot_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QueuePtrW + 1)'(push_i) - (QueuePtrW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### hw/rtl/mfbs_back.sv
// Back end: owns the frame store, runs fills, pixel writes and line emits.
// Depends on mfbs_pkg; takes commands from mfbs_fifo.
module mfbs_back import mfbs_pkg::*; #(
  parameter int unsigned DISPLAY_COLS = 200,
  parameter int unsigned DISPLAY_ROWS = 150
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       queue_empty_i,
  output logic       pop_o,
  output logic       init_busy_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       line_last_o,
  output logic       frame_last_o
);

  localparam int unsigned Stride     = (DISPLAY_COLS + 7) / 8;
  localparam int unsigned StoreBytes = Stride * DISPLAY_ROWS;
  localparam int unsigned AddrW      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam int unsigned XW         = (Stride > 1) ? $clog2(Stride) : 1;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_FILL    = 7'b0000010,
    ST_SET_RD  = 7'b0000100,
    ST_SET_WR  = 7'b0001000,
    ST_EMIT_RD = 7'b0010000,
    ST_EMIT_HI = 7'b0100000,
    ST_EMIT_LO = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [XW-1:0]    x_q, x_d;
  logic [7:0]       row_q, row_d;
  logic             rep_q, rep_d;
  logic [7:0]       fill_q, fill_d;
  logic [7:0]       mask_q, mask_d;
  logic             black_q, black_d;
  logic             init_q, init_d;
  logic             ovalid_q, ovalid_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             oline_q, oline_d;
  logic             oframe_q, oframe_d;

  logic [7:0]       mem_q [StoreBytes];
  logic [7:0]       rd_q;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;

  logic [15:0]      wide;
  logic             out_free;
  logic             last_x;
  logic             last_row;

  assign wide     = widen_byte(rd_q);
  assign out_free = !ovalid_q || !out_stall_i;
  assign last_x   = x_q == XW'(Stride - 1);
  assign last_row = (row_q == 8'(DISPLAY_ROWS - 1)) && rep_q;

  // Sequence commands
  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    base_d   = base_q;
    x_d      = x_q;
    row_d    = row_q;
    rep_d    = rep_q;
    fill_d   = fill_q;
    mask_d   = mask_q;
    black_d  = black_q;
    init_d   = init_q;
    ovalid_d = out_stall_i ? ovalid_q : 1'b0;
    obyte_d  = obyte_q;
    oline_d  = oline_q;
    oframe_d = oframe_q;
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = addr_q;
    wr_en    = 1'b0;
    wr_addr  = addr_q;
    wr_data  = fill_q;

    case (state_q)
      ST_IDLE: begin
        if (!queue_empty_i) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_CLEAR: begin
              fill_d  = cmd_i.data;
              addr_d  = '0;
              state_d = ST_FILL;
            end
            CMD_SET: begin
              addr_d  = cmd_i.addr[AddrW-1:0];
              mask_d  = cmd_i.mask;
              black_d = cmd_i.data == ColourBlack;
              state_d = ST_SET_RD;
            end
            CMD_EMIT: begin
              addr_d  = base_q;
              x_d     = '0;
              state_d = ST_EMIT_RD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // Write one byte a cycle over the whole store
      ST_FILL: begin
        wr_en = 1'b1;
        if (addr_q == AddrW'(StoreBytes - 1)) begin
          init_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + AddrW'(1);
        end
      end

      ST_SET_RD: begin
        rd_en   = 1'b1;
        state_d = ST_SET_WR;
      end

      // Modify the read byte and write it back
      ST_SET_WR: begin
        wr_en   = 1'b1;
        wr_data = black_q ? (rd_q & ~mask_q) : (rd_q | mask_q);
        state_d = ST_IDLE;
      end

      ST_EMIT_RD: begin
        rd_en   = 1'b1;
        state_d = ST_EMIT_HI;
      end

      ST_EMIT_HI: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = wide[15:8];
          oline_d  = 1'b0;
          oframe_d = 1'b0;
          state_d  = ST_EMIT_LO;
        end
      end

      // Send the low half and prefetch the next source byte
      ST_EMIT_LO: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = wide[7:0];
          oline_d  = last_x;
          oframe_d = last_x && last_row;
          if (last_x) begin
            state_d = ST_IDLE;
            if (!rep_q) begin
              rep_d = 1'b1;
            end else begin
              rep_d = 1'b0;
              if (row_q == 8'(DISPLAY_ROWS - 1)) begin
                row_d  = '0;
                base_d = '0;
              end else begin
                row_d  = row_q + 8'd1;
                base_d = base_q + AddrW'(Stride);
              end
            end
          end else begin
            x_d     = x_q + XW'(1);
            addr_d  = addr_q + AddrW'(1);
            rd_en   = 1'b1;
            rd_addr = addr_q + AddrW'(1);
            state_d = ST_EMIT_HI;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the initial fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FILL;
      addr_q   <= '0;
      base_q   <= '0;
      x_q      <= '0;
      row_q    <= '0;
      rep_q    <= 1'b0;
      fill_q   <= ResetFill;
      init_q   <= 1'b1;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      base_q   <= base_d;
      x_q      <= x_d;
      row_q    <= row_d;
      rep_q    <= rep_d;
      fill_q   <= fill_d;
      init_q   <= init_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mask_q   <= mask_d;
    black_q  <= black_d;
    obyte_q  <= obyte_d;
    oline_q  <= oline_d;
    oframe_q <= oframe_d;
  end

  // Frame store: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign init_busy_o  = init_q;
  assign out_valid_o  = ovalid_q;
  assign out_byte_o   = obyte_q;
  assign line_last_o  = oline_q;
  assign frame_last_o = oframe_q;

endmodule

### hw/rtl/mono_framebuffer_2x_scaler.sv
// Top level of the monochrome frame buffer with 2x pixel doubling.
// Depends on mfbs_pkg, mfbs_front, mfbs_fifo, mfbs_back and the macros header.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | input     | in_valid/in_stall   | operation, pixel_col, pixel_row, value
//  out     | output    | out_valid/out_stall | out_byte, line_last, frame_last
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data (keep orientation)
//
// An emit sends one output byte a cycle while the output is not stalled, set by
// the single read port of the frame store. A set pixel is a read-modify-write,
// a clear writes the whole store, one byte per cycle. After reset the store is
// filled with 0xFF, during which input beats are stalled; config writes are
// always taken. A stalled output holds the back end; the two-entry queue keeps
// the front open until it fills.
`include "mono_framebuffer_2x_scaler_macros.svh"

module mono_framebuffer_2x_scaler import mfbs_pkg::*; #(
  parameter int unsigned DISPLAY_COLS = 200,
  parameter int unsigned DISPLAY_ROWS = 150
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] pixel_col_i,
  input  logic [7:0] pixel_row_i,
  input  logic [7:0] value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       line_last_o,
  output logic       frame_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  logic       orient_keep_q, orient_keep_d;
  front_ctl_t front_ctl;
  logic       push;
  cmd_t       cmd_front;
  cmd_t       cmd_back;
  logic       pop;
  logic       queue_full;
  logic       queue_empty;
  logic       init_busy;

  // Take config beats at any time
  assign cfg_ready_o   = 1'b1;
  assign orient_keep_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : orient_keep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_keep_q <= 1'b0;
    end else begin
      orient_keep_q <= orient_keep_d;
    end
  end

  assign front_ctl.queue_full = queue_full;
  assign front_ctl.init_busy  = init_busy;

  mfbs_front #(
    .DISPLAY_COLS(DISPLAY_COLS),
    .DISPLAY_ROWS(DISPLAY_ROWS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .pixel_col_i  (pixel_col_i),
    .pixel_row_i  (pixel_row_i),
    .value_i      (value_i),
    .orient_keep_i(orient_keep_q),
    .ctl_i        (front_ctl),
    .push_o       (push),
    .cmd_o        (cmd_front)
  );

  mfbs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_front),
    .pop_i  (pop),
    .cmd_o  (cmd_back),
    .full_o (queue_full),
    .empty_o(queue_empty)
  );

  mfbs_back #(
    .DISPLAY_COLS(DISPLAY_COLS),
    .DISPLAY_ROWS(DISPLAY_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_back),
    .queue_empty_i(queue_empty),
    .pop_o        (pop),
    .init_busy_o  (init_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .line_last_o  (line_last_o),
    .frame_last_o (frame_last_o)
  );

  // Frame end always closes a line
  `MFBS_ASSERT_NOW(a_frame_in_line, out_valid_o && frame_last_o, line_last_o, "frame end mid line")

  // No output while the store is still being initialized
  `MFBS_ASSERT_NOW(a_no_out_in_init, init_busy, !out_valid_o, "output beat during initial fill")

  // Nothing is queued once the initial fill ends
  `MFBS_ASSERT_NOW(a_queue_empty_init, $fell(init_busy), queue_empty, "queued during fill")

  // Never push into a full queue
  `MFBS_ASSERT_NEXT(a_no_overflow, queue_full && !pop, !push || queue_full, "queue overflow")

endmodule
